FILE: src/tnpc_pkg.sv
// ----------------------------------------------------------------------------
// tnpc_pkg
// Shared types and class codes for the Thumb next-address unit.
// ----------------------------------------------------------------------------
package tnpc_pkg;

	localparam int unsigned ADDR_W  = 32;
	localparam int unsigned WORD_W  = 16;
	localparam int unsigned FLAGS_W = 4;
	localparam int unsigned CLASS_W = 6;

	typedef logic [ADDR_W-1:0]  addr_t;
	typedef logic [WORD_W-1:0]  word_t;
	typedef logic [FLAGS_W-1:0] flags_t;
	typedef logic [CLASS_W-1:0] class_t;

	// class numbers; bases are offset by opcode fields in the decoder
	localparam class_t CLS_SHIFT_IMM = 6'd0;
	localparam class_t CLS_ADDSUB_REG = 6'd3;
	localparam class_t CLS_ADDSUB_IMM = 6'd5;
	localparam class_t CLS_IMM8      = 6'd7;
	localparam class_t CLS_ALU       = 6'd11;
	localparam class_t CLS_HI_ADD    = 6'd27;
	localparam class_t CLS_HI_CMP    = 6'd28;
	localparam class_t CLS_HI_MOV    = 6'd29;
	localparam class_t CLS_BX        = 6'd30;
	localparam class_t CLS_LDR_PC    = 6'd31;
	localparam class_t CLS_LS_REG    = 6'd32;
	localparam class_t CLS_LS_IMM    = 6'd40;
	localparam class_t CLS_LS_HALF   = 6'd44;
	localparam class_t CLS_LS_SP     = 6'd46;
	localparam class_t CLS_ADD_PCSP  = 6'd48;
	localparam class_t CLS_SP_ADJ    = 6'd50;
	localparam class_t CLS_PUSH_POP  = 6'd52;
	localparam class_t CLS_LDM_STM   = 6'd54;
	localparam class_t CLS_SWI       = 6'd56;
	localparam class_t CLS_BCC       = 6'd57;
	localparam class_t CLS_B         = 6'd58;
	localparam class_t CLS_BL_HI     = 6'd59;
	localparam class_t CLS_BL_LO     = 6'd60;
	localparam class_t CLS_UNKNOWN   = 6'd61;

	typedef enum logic [3:0] {
		COND_EQ, COND_NE, COND_CS, COND_CC,
		COND_MI, COND_PL, COND_VS, COND_VC,
		COND_HI, COND_LS, COND_GE, COND_LT,
		COND_GT, COND_LE, COND_AL, COND_NV
	} cond_t;

	typedef struct packed {
		logic  wr;
		addr_t value;
	} link_upd_t;

endpackage

FILE: src/tnpc_if.sv
// ----------------------------------------------------------------------------
// tnpc_if
// Valid/ready channels for instruction items and next-address items.
// ----------------------------------------------------------------------------
interface tnpc_instr_if;
	logic                  valid;
	logic                  ready;
	logic [15:0]           instr_word;
	logic [31:0]           instr_addr;
	logic [3:0]            cond_flags;
	logic [31:0]           src_reg_value;
	logic [31:0]           pc_reg_value;

	modport source (output valid, instr_word, instr_addr, cond_flags,
		src_reg_value, pc_reg_value, input ready);
	modport sink (input valid, instr_word, instr_addr, cond_flags,
		src_reg_value, pc_reg_value, output ready);
endinterface

interface tnpc_result_if;
	logic        valid;
	logic        ready;
	logic [31:0] next_addr;
	logic [5:0]  instr_class;

	modport source (output valid, next_addr, instr_class, input ready);
	modport sink (input valid, next_addr, instr_class, output ready);
endinterface

FILE: src/tnpc_classify.sv
// ----------------------------------------------------------------------------
// tnpc_classify
// Sort a Thumb halfword into one of 62 instruction classes.
// ----------------------------------------------------------------------------
module tnpc_classify (
	input  tnpc_pkg::word_t  instr_word,
	output tnpc_pkg::class_t instr_class
);
	import tnpc_pkg::*;

	word_t w;
	assign w = instr_word;

	always_comb begin
		instr_class = CLS_UNKNOWN;
		unique case (w[15:13])
			3'd0: begin
				if (w[12:11] != 2'd3)
					instr_class = CLS_SHIFT_IMM + {4'd0, w[12:11]};
				else if (!w[10])
					instr_class = CLS_ADDSUB_REG + {5'd0, w[9]};
				else
					instr_class = CLS_ADDSUB_IMM + {5'd0, w[9]};
			end
			3'd1: instr_class = CLS_IMM8 + {4'd0, w[12:11]};
			3'd2: begin
				unique case (w[12:10])
					3'd0:       instr_class = CLS_ALU + {2'd0, w[9:6]};
					3'd1:       instr_class = CLS_HI_ADD + {4'd0, w[9:8]};
					3'd2, 3'd3: instr_class = CLS_LDR_PC;
					default:    instr_class = CLS_LS_REG + {3'd0, w[11:9]};
				endcase
			end
			3'd3: instr_class = CLS_LS_IMM + {4'd0, w[12:11]};
			3'd4: begin
				if (!w[12])
					instr_class = CLS_LS_HALF + {5'd0, w[11]};
				else
					instr_class = CLS_LS_SP + {5'd0, w[11]};
			end
			3'd5: begin
				if (!w[12])
					instr_class = CLS_ADD_PCSP + {5'd0, w[11]};
				else if (w[11:8] == 4'd0)
					instr_class = CLS_SP_ADJ + {5'd0, w[7]};
				else
					instr_class = CLS_PUSH_POP + {5'd0, w[11]};
			end
			3'd6: begin
				if (!w[12])
					instr_class = CLS_LDM_STM + {5'd0, w[11]};
				else if (w[11:8] == 4'hF)
					instr_class = CLS_SWI;
				else
					instr_class = CLS_BCC;
			end
			default: begin
				unique case (w[12:11])
					2'd0:    instr_class = CLS_B;
					2'd1:    instr_class = CLS_UNKNOWN;
					2'd2:    instr_class = CLS_BL_HI;
					default: instr_class = CLS_BL_LO;
				endcase
			end
		endcase
	end

endmodule

FILE: src/tnpc_target.sv
// ----------------------------------------------------------------------------
// tnpc_target
// Work out the next address and the link update for one classified item.
// ----------------------------------------------------------------------------
module tnpc_target (
	input  tnpc_pkg::class_t    instr_class,
	input  tnpc_pkg::word_t     instr_word,
	input  tnpc_pkg::addr_t     instr_addr,
	input  tnpc_pkg::flags_t    cond_flags,
	input  tnpc_pkg::addr_t     src_reg_value,
	input  tnpc_pkg::addr_t     pc_reg_value,
	input  tnpc_pkg::addr_t     link_target,
	output tnpc_pkg::addr_t     next_addr,
	output tnpc_pkg::link_upd_t link_upd
);
	import tnpc_pkg::*;

	function automatic logic cond_pass(input cond_t code, input flags_t f);
		logic n, z, c, v;
		n = f[3];
		z = f[2];
		c = f[1];
		v = f[0];
		case (code)
			COND_EQ: cond_pass = z;
			COND_NE: cond_pass = !z;
			COND_CS: cond_pass = c;
			COND_CC: cond_pass = !c;
			COND_MI: cond_pass = n;
			COND_PL: cond_pass = !n;
			COND_VS: cond_pass = v;
			COND_VC: cond_pass = !v;
			COND_HI: cond_pass = c && !z;
			COND_LS: cond_pass = !c || z;
			COND_GE: cond_pass = (n == v);
			COND_LT: cond_pass = (n != v);
			COND_GT: cond_pass = !z && (n == v);
			COND_LE: cond_pass = z || (n != v);
			COND_AL: cond_pass = 1'b1;
			default: cond_pass = 1'b0;
		endcase
	endfunction

	word_t w;
	addr_t fall_thru;
	addr_t bcc_off;
	addr_t b_off;
	addr_t bl_hi_off;
	addr_t bl_lo_off;
	logic  rd_is_pc;

	assign w         = instr_word;
	assign fall_thru = instr_addr + 32'd2;
	assign bcc_off   = {{23{w[7]}}, w[7:0], 1'b0};
	assign b_off     = {{20{w[10]}}, w[10:0], 1'b0};
	assign bl_hi_off = {{9{w[10]}}, w[10:0], 12'd0};
	assign bl_lo_off = {20'd0, w[10:0], 1'b0};
	assign rd_is_pc  = ({w[7], w[2:0]} == 4'hF);

	always_comb begin
		next_addr = fall_thru;
		case (instr_class)
			CLS_HI_ADD: if (rd_is_pc) next_addr = src_reg_value + pc_reg_value;
			CLS_HI_MOV: if (rd_is_pc) next_addr = src_reg_value;
			CLS_BX:     next_addr = {src_reg_value[31:1], 1'b0};
			CLS_BCC: begin
				if (cond_pass(cond_t'(w[11:8]), cond_flags))
					next_addr = instr_addr + bcc_off + 32'd4;
			end
			CLS_B:      next_addr = instr_addr + b_off + 32'd4;
			CLS_BL_LO:  next_addr = link_target + bl_lo_off;
			default:    next_addr = fall_thru;
		endcase
	end

	assign link_upd.wr    = (instr_class == CLS_BL_HI);
	assign link_upd.value = instr_addr + bl_hi_off + 32'd4;

endmodule

FILE: src/thumb_next_pc_calculator.sv
// Path: an accepted item goes through the input register, then the result register.
// Throughput: one item per cycle; the input register and the result register
// each advance whenever the result register is empty or being taken.
// Reset: arst_n clears both stage valid bits and the BL link target to zero.
// ----------------------------------------------------------------------------
// thumb_next_pc_calculator
// Classify a Thumb halfword and give the address of the next instruction.
// ----------------------------------------------------------------------------
module thumb_next_pc_calculator (
	input logic          clk,
	input logic          arst_n,
	tnpc_instr_if.sink   instr,
	tnpc_result_if.source result
);
	import tnpc_pkg::*;

	// stage 1: registered input item
	logic   valid_s1;
	word_t  word_s1;
	addr_t  addr_s1;
	flags_t flags_s1;
	addr_t  src_s1;
	addr_t  pcv_s1;

	// stage 2: registered result item
	logic   valid_s2;
	addr_t  next_s2;
	class_t class_s2;

	// partial target left by the first BL half
	addr_t  link_target_q;

	logic      advance;
	class_t    cls;
	addr_t     next_addr;
	link_upd_t link_upd;

	// Move stage 1 into the result register when it is free or being drained.
	assign advance     = !valid_s2 || result.ready;
	assign instr.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (instr.ready) begin
			valid_s1 <= instr.valid;
		end
	end

	// Payload needs no reset; load only on an accepted item.
	always_ff @(posedge clk) begin
		if (instr.valid && instr.ready) begin
			word_s1  <= instr.instr_word;
			addr_s1  <= instr.instr_addr;
			flags_s1 <= instr.cond_flags;
			src_s1   <= instr.src_reg_value;
			pcv_s1   <= instr.pc_reg_value;
		end
	end

	tnpc_classify u_classify (
		.instr_word  (word_s1),
		.instr_class (cls)
	);

	// The link target is read here and written on the same edge that retires
	// the item, so a second BL half right behind a first sees the new value.
	tnpc_target u_target (
		.instr_class   (cls),
		.instr_word    (word_s1),
		.instr_addr    (addr_s1),
		.cond_flags    (flags_s1),
		.src_reg_value (src_s1),
		.pc_reg_value  (pcv_s1),
		.link_target   (link_target_q),
		.next_addr     (next_addr),
		.link_upd      (link_upd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2      <= 1'b0;
			link_target_q <= '0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
			if (valid_s1 && link_upd.wr)
				link_target_q <= link_upd.value;
		end
	end

	// Hold the result while the sink stalls.
	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			next_s2  <= next_addr;
			class_s2 <= cls;
		end
	end

	assign result.valid       = valid_s2;
	assign result.next_addr   = next_s2;
	assign result.instr_class = class_s2;

endmodule
